### design/rtac_pkg.sv
// Shared types and codes for the radio transmit retry and acknowledge controller.
// Depends on nothing; every other design file imports it.
package rtac_pkg;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_SEND     = 3'd1,
    CMD_TX_DONE  = 3'd2,
    CMD_ACK_RX   = 3'd3,
    CMD_ACK_NEED = 3'd4,
    CMD_CLR_STAT = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_RX     = 3'd1,
    MODE_TX     = 3'd2,
    MODE_WAIT   = 3'd3,
    MODE_ADELAY = 3'd4,
    MODE_ACKTX  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    RES_IDLE      = 3'd0,
    RES_BUSY      = 3'd1,
    RES_DELIVERED = 3'd2,
    RES_ABORTED   = 3'd3,
    RES_NOACK     = 3'd4
  } result_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_DATA = 2'd1,
    ACT_ACK  = 2'd2
  } action_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TX_TIMEOUT  = 3'd0,
    REG_ACK_DELAY   = 3'd1,
    REG_ACK_WAIT    = 3'd2,
    REG_RETRY_LIMIT = 3'd3,
    REG_SLEEP_DONE  = 3'd4
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0] TxTimeoutRst  = 8'd15;
  localparam logic [7:0] AckDelayRst   = 8'd10;
  localparam logic [7:0] AckWaitRst    = 8'd50;
  localparam logic [2:0] RetryLimitRst = 3'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] peer_addr;
    logic [7:0] msg_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  tx_result;
    logic [7:0]  pkt_dest;
    logic [7:0]  pkt_msgid;
    logic [2:0]  link_state;
    logic [15:0] retries_total;
    logic [15:0] failures_total;
    logic [15:0] acks_sent_total;
    logic [15:0] unexpected_acks;
    logic [15:0] stray_events;
  } out_item_t;

  typedef struct packed {
    logic [7:0] tx_timeout_ticks;
    logic [7:0] ack_delay_ticks;
    logic [7:0] ack_wait_ticks;
    logic [2:0] retry_limit;
    logic       sleep_when_done;
  } cfg_t;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  tick;
    logic        timer_run;
    logic [2:0]  resend;
    logic [7:0]  cur_msgid;
    logic [7:0]  cur_dest;
    logic [7:0]  ack_peer;
    logic [7:0]  ack_mid;
    result_e     last_result;
    logic [15:0] retries;
    logic [15:0] fails;
    logic [15:0] acks;
    logic [15:0] unexp;
    logic [15:0] stray;
  } link_t;

endpackage

### design/rtac_cfg.sv
// Configuration register file of the controller: timeouts, retry limit, sleep flag.
// Depends on rtac_pkg.
module rtac_cfg
  import rtac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tx_timeout_ticks <= TxTimeoutRst;
      cfg_q.ack_delay_ticks  <= AckDelayRst;
      cfg_q.ack_wait_ticks   <= AckWaitRst;
      cfg_q.retry_limit      <= RetryLimitRst;
      cfg_q.sleep_when_done  <= 1'b0;
    end else if (cfg_we_i) begin
      // indexes beyond the list drop the write
      case (cfg_idx_i)
        REG_TX_TIMEOUT:  cfg_q.tx_timeout_ticks <= cfg_wdata_i;
        REG_ACK_DELAY:   cfg_q.ack_delay_ticks  <= cfg_wdata_i;
        REG_ACK_WAIT:    cfg_q.ack_wait_ticks   <= cfg_wdata_i;
        REG_RETRY_LIMIT: cfg_q.retry_limit      <= cfg_wdata_i[2:0];
        REG_SLEEP_DONE:  cfg_q.sleep_when_done  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/rtac_step.sv
// Event processing of the controller: next link state and result word for one event.
// Depends on rtac_pkg.
module rtac_step
  import rtac_pkg::*;
(
  input  cfg_t      cfg_i,
  input  link_t     cur_i,
  input  in_item_t  item_i,
  output link_t     nxt_o,
  output out_item_t res_o
);

  logic [7:0] tick_inc;
  action_e    action;
  link_t      ns;

  assign tick_inc = cur_i.tick + 8'd1;

  always_comb begin
    ns     = cur_i;
    action = ACT_NONE;
    unique case (cmd_e'(item_i.command))
      CMD_TICK: begin
        if (cur_i.timer_run) begin
          ns.tick = tick_inc;
          priority if ((cur_i.mode == MODE_TX && tick_inc == cfg_i.tx_timeout_ticks) ||
                       (cur_i.mode == MODE_WAIT && tick_inc == cfg_i.ack_wait_ticks)) begin
            if (cur_i.resend < cfg_i.retry_limit) begin
              // resend the data word
              ns.resend    = cur_i.resend + 3'd1;
              ns.retries   = cur_i.retries + 16'd1;
              ns.tick      = '0;
              ns.timer_run = 1'b1;
              ns.mode      = MODE_TX;
              action       = ACT_DATA;
            end else begin
              ns.fails       = cur_i.fails + 16'd1;
              ns.last_result = (cur_i.mode == MODE_TX) ? RES_ABORTED : RES_NOACK;
              ns.timer_run   = 1'b0;
              ns.tick        = '0;
              ns.mode        = cfg_i.sleep_when_done ? MODE_IDLE : MODE_RX;
            end
          end else if (cur_i.mode == MODE_ADELAY) begin
            if (tick_inc == cfg_i.ack_delay_ticks) begin
              ns.timer_run = 1'b0;
              ns.tick      = '0;
              ns.mode      = MODE_ACKTX;
              action       = ACT_ACK;
            end
          end else if (cur_i.mode != MODE_TX && cur_i.mode != MODE_WAIT) begin
            // running timer in a state without a timeout
            ns.timer_run = 1'b0;
            ns.tick      = '0;
            ns.stray     = cur_i.stray + 16'd1;
          end
        end
      end
      CMD_SEND: begin
        if (cur_i.mode == MODE_IDLE || cur_i.mode == MODE_RX) begin
          ns.resend      = '0;
          ns.cur_dest    = item_i.peer_addr;
          ns.cur_msgid   = cur_i.cur_msgid + 8'd1;
          ns.last_result = RES_BUSY;
          ns.mode        = MODE_TX;
          ns.tick        = '0;
          ns.timer_run   = 1'b1;
          action         = ACT_DATA;
        end
      end
      CMD_TX_DONE: begin
        if (cur_i.mode == MODE_TX) begin
          ns.mode      = MODE_WAIT;
          ns.tick      = '0;
          ns.timer_run = 1'b1;
        end else if (cur_i.mode == MODE_ACKTX) begin
          ns.acks      = cur_i.acks + 16'd1;
          ns.timer_run = 1'b0;
          ns.tick      = '0;
          ns.mode      = cfg_i.sleep_when_done ? MODE_IDLE : MODE_RX;
        end else begin
          ns.stray = cur_i.stray + 16'd1;
        end
      end
      CMD_ACK_RX: begin
        if (cur_i.mode != MODE_WAIT) begin
          ns.unexp = cur_i.unexp + 16'd1;
        end else if (item_i.msg_id == cur_i.cur_msgid &&
                     item_i.peer_addr == cur_i.cur_dest) begin
          ns.last_result = RES_DELIVERED;
          ns.timer_run   = 1'b0;
          ns.tick        = '0;
          ns.mode        = cfg_i.sleep_when_done ? MODE_IDLE : MODE_RX;
        end
      end
      CMD_ACK_NEED: begin
        if (cur_i.mode == MODE_IDLE || cur_i.mode == MODE_RX) begin
          ns.ack_peer  = item_i.peer_addr;
          ns.ack_mid   = item_i.msg_id;
          ns.mode      = MODE_ADELAY;
          ns.tick      = '0;
          ns.timer_run = 1'b1;
        end
      end
      CMD_CLR_STAT: begin
        ns.retries = '0;
        ns.fails   = '0;
        ns.acks    = '0;
        ns.unexp   = '0;
        ns.stray   = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.action    = action;
    res_o.tx_result = ns.last_result;
    unique case (action)
      ACT_DATA: begin
        res_o.pkt_dest  = ns.cur_dest;
        res_o.pkt_msgid = ns.cur_msgid;
      end
      ACT_ACK: begin
        res_o.pkt_dest  = ns.ack_peer;
        res_o.pkt_msgid = ns.ack_mid;
      end
      default: begin
        res_o.pkt_dest  = '0;
        res_o.pkt_msgid = '0;
      end
    endcase
    res_o.link_state      = ns.mode;
    res_o.retries_total   = ns.retries;
    res_o.failures_total  = ns.fails;
    res_o.acks_sent_total = ns.acks;
    res_o.unexpected_acks = ns.unexp;
    res_o.stray_events    = ns.stray;
  end

  assign nxt_o = ns;

endmodule

### design/radio_tx_retry_ack_controller.sv
// Stop-and-wait transmit retry and acknowledge controller, top level.
// The result word of an accepted event word is registered and shown in the cycle after it is accepted.
// Throughput: one event word per cycle while result words are taken; the single step of link-state logic sets it.
// The result register frees as its word is taken, so input and output overlap.
// Reset (async, active low) puts the link idle, clears counters and loads
// default timeouts. Depends on rtac_pkg, rtac_cfg and rtac_step.
module radio_tx_retry_ack_controller
  import rtac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  link_t     link_q, link_d;
  out_item_t res_d, res_q;
  logic      out_valid_q;
  logic      accept;

  rtac_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rtac_step u_step (
    .cfg_i  (cfg),
    .cur_i  (link_q),
    .item_i (in_data_i),
    .nxt_o  (link_d),
    .res_o  (res_d)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // all-zero leaves the link idle
      link_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        link_q <= link_d;
      end
      // hold the result word until taken
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule
